FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define R2_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication
`define R2_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   `R2_ASSERT(lbl, clk, rst, ante |-> cons, msg)

// next-cycle implication
`define R2_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   `R2_ASSERT(lbl, clk, rst, ante |=> cons, msg)

`endif

FILE: rtl/r2fft_pkg.sv
package r2fft_pkg;

   localparam int DATA_W   = 36;
   localparam int SAMPLE_W = 24;
   localparam int INDEX_W  = 10;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // register index, taken from paddr[2]
   localparam logic REG_LOG2_SIZE = 1'b0;
   localparam logic REG_INVERSE   = 1'b1;

   localparam logic [3:0] LOG2_SIZE_RESET = 4'd10;

   typedef struct packed {
      logic [3:0] log2_size;
      logic       inverse_mode;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_BR_RD,
      ST_BR_W1,
      ST_BR_W2,
      ST_BF_RD,
      ST_BF_MUL,
      ST_BF_RND,
      ST_BF_WE,
      ST_BF_WO,
      ST_DV_RD,
      ST_DV_WR,
      ST_DONE
   } state_type;

   // saturate a sum with three growth bits back to the data width
   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [DATA_W+2:0] v);
      logic signed [DATA_W-1:0] res;
      if (v[DATA_W+2:DATA_W-1] == '0 || v[DATA_W+2:DATA_W-1] == '1) begin
         res = v[DATA_W-1:0];
      end else if (v[DATA_W+2]) begin
         res = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

FILE: rtl/r2fft_ifs.sv
interface r2fft_req_if;
   import r2fft_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 mode;
   logic [INDEX_W-1:0]         elem_index;
   logic signed [SAMPLE_W-1:0] in_re;
   logic signed [SAMPLE_W-1:0] in_im;
   modport source (output valid, mode, elem_index, in_re, in_im, input ready);
   modport sink (input valid, mode, elem_index, in_re, in_im, output ready);
endinterface

interface r2fft_rsp_if;
   import r2fft_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] out_re;
   logic signed [DATA_W-1:0] out_im;
   logic [1:0]               ack_kind;
   modport source (output valid, out_re, out_im, ack_kind, input ready);
   modport sink (input valid, out_re, out_im, ack_kind, output ready);
endinterface

FILE: rtl/r2fft_csr.sv
module r2fft_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [r2fft_pkg::CSR_AW-1:0] paddr,
   input  logic [r2fft_pkg::CSR_DW-1:0] pwdata,
   output logic [r2fft_pkg::CSR_DW-1:0] prdata,
   output logic                        pready,
   output r2fft_pkg::cfg_type          cfg
);
   import r2fft_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_LOG2_SIZE: cfg_in.log2_size    = pwdata[3:0];
            REG_INVERSE:   cfg_in.inverse_mode = pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_LOG2_SIZE: prdata = {{(CSR_DW-4){1'b0}}, cfg_ff.log2_size};
         REG_INVERSE:   prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.inverse_mode};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.log2_size    <= LOG2_SIZE_RESET;
         cfg_ff.inverse_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/r2fft_twiddle.sv
module r2fft_twiddle #(
   parameter int MAX_POINTS   = 1024,
   parameter int TWIDDLE_BITS = 18
) (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [$clog2(MAX_POINTS)-1:0]       tw_idx,
   input  logic                                inverse,
   output logic signed [TWIDDLE_BITS-1:0]      w_re,
   output logic signed [TWIDDLE_BITS-1:0]      w_im
);
   import r2fft_pkg::*;

   localparam int AW     = $clog2(MAX_POINTS);
   localparam int TW     = TWIDDLE_BITS;
   localparam int FRAC_W = TW - 1;
   localparam int RSH    = (FRAC_W < 30) ? 30 - FRAC_W : 0;
   localparam int LSH    = (FRAC_W < 30) ? 0 : FRAC_W - 30;
   localparam logic [63:0] RND      = (RSH > 0) ? (64'd1 << (RSH - 1)) : 64'd0;
   localparam logic [63:0] ONE_Q30  = 64'd1073741824;
   localparam logic [63:0] HALF_PI  = 64'd1686629713;
   localparam logic [63:0] CAP      = (64'd1 << FRAC_W) - 64'd1;

   // cos(pi/2 * r / MAX_POINTS): Taylor series in Horner form, Q30, truncating steps
   function automatic logic [63:0] quarter_cos(input logic [63:0] r);
      logic [63:0] a, x2, t, q, c;
      a  = (HALF_PI * r) / MAX_POINTS;
      x2 = (a * a) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd182;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd132;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd90;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd56;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd12;
      q  = ((x2 * t) >> 30) >> 1;
      c  = (ONE_Q30 > q) ? ONE_Q30 - q : 64'd0;
      if (RSH > 0) begin
         c = (c + RND) >> RSH;
      end else begin
         c = c << LSH;
      end
      if (c > CAP) begin
         c = CAP;
      end
      return c;
   endfunction

   logic [FRAC_W-1:0] rom [MAX_POINTS+1];

   for (genvar g = 0; g <= MAX_POINTS; g++) begin : g_rom
      assign rom[g] = FRAC_W'(quarter_cos(64'(g)));
   end

   logic [AW+1:0]      u;
   logic [1:0]         quad;
   logic [AW-1:0]      r_idx;
   logic [FRAC_W-1:0]  cr_ff, cn_ff;
   logic [1:0]         quad_ff;
   logic               inv_ff;
   logic signed [TW-1:0] cr, cn, c, s;

   assign u     = {tw_idx, 2'b00};
   assign quad  = u[AW+1:AW];
   assign r_idx = u[AW-1:0];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         cr_ff   <= rom[r_idx];
         cn_ff   <= rom[(AW+1)'(MAX_POINTS) - {1'b0, r_idx}];
         quad_ff <= quad;
         inv_ff  <= inverse;
      end
   end

   assign cr = $signed({1'b0, cr_ff});
   assign cn = $signed({1'b0, cn_ff});

   always_comb begin
      case (quad_ff)
         2'd0:    begin c = cr;  s = cn;  end
         2'd1:    begin c = -cn; s = cr;  end
         2'd2:    begin c = -cr; s = -cn; end
         default: begin c = cn;  s = -cr; end
      endcase
   end

   assign w_re = c;
   assign w_im = inv_ff ? s : -s;

endmodule

FILE: rtl/r2fft_butterfly.sv
module r2fft_butterfly #(
   parameter int TWIDDLE_BITS = 18
) (
   input  logic                                   clock,
   input  logic                                   mul_en,
   input  logic                                   rnd_en,
   input  logic signed [r2fft_pkg::DATA_W-1:0]    o_re,
   input  logic signed [r2fft_pkg::DATA_W-1:0]    o_im,
   input  logic signed [TWIDDLE_BITS-1:0]         w_re,
   input  logic signed [TWIDDLE_BITS-1:0]         w_im,
   output logic signed [r2fft_pkg::DATA_W+1:0]    t_re,
   output logic signed [r2fft_pkg::DATA_W+1:0]    t_im
);
   import r2fft_pkg::*;

   localparam int TW     = TWIDDLE_BITS;
   localparam int FRAC_W = TW - 1;
   localparam int PW     = DATA_W + TW;
   localparam int RW     = DATA_W + 1;

   // product / 2^FRAC_W, nearest, ties away from zero
   function automatic logic signed [RW-1:0] round_prod(input logic signed [PW-1:0] p);
      logic [PW:0] mag, rr;
      mag = p[PW-1] ? -{p[PW-1], p} : {1'b0, p};
      rr  = (mag + ((PW+1)'(1) << (FRAC_W - 1))) >> FRAC_W;
      return p[PW-1] ? -$signed(RW'(rr)) : $signed(RW'(rr));
   endfunction

   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [RW:0]   t_re_ff, t_im_ff;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         p_rr_ff <= o_re * w_re;
         p_ii_ff <= o_im * w_im;
         p_ri_ff <= o_re * w_im;
         p_ir_ff <= o_im * w_re;
      end
      if (rnd_en) begin
         t_re_ff <= (RW+1)'(round_prod(p_rr_ff)) - (RW+1)'(round_prod(p_ii_ff));
         t_im_ff <= (RW+1)'(round_prod(p_ri_ff)) + (RW+1)'(round_prod(p_ir_ff));
      end
   end

   assign t_re = t_re_ff;
   assign t_im = t_im_ff;

endmodule

FILE: rtl/radix2_complex_fft.sv
// Channel   Port group           Carries
// request   req (valid/ready)    mode, elem_index, in_re, in_im
// response  rsp (valid/ready)    out_re, out_im, ack_kind
// config    psel..pready (APB)   log2_size @0x0, inverse_mode @0x4
//
// Load: one request per cycle while responses are taken. Read: synchronous memory read,
// response from ST_RD_WAIT. Start: bit-reverse pass (ST_BR_RD, swaps via ST_BR_W1/W2),
// then (N/2)*log2N butterflies (ST_BF_*), inverse-mode scaling (ST_DV_*), ST_DONE.
// One butterfly at a time: read, multiply, round, then two writes on the single write port.
// Synchronous active-high reset clears control and config; memory contents are not cleared.
// A held response blocks new requests until it is taken.
`include "assert_macros.svh"

module radix2_complex_fft #(
   parameter int MAX_POINTS   = 1024,
   parameter int TWIDDLE_BITS = 18
) (
   input  logic                         clock,
   input  logic                         reset,
   r2fft_req_if.sink                    req,
   r2fft_rsp_if.source                  rsp,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [r2fft_pkg::CSR_AW-1:0] paddr,
   input  logic [r2fft_pkg::CSR_DW-1:0] pwdata,
   output logic [r2fft_pkg::CSR_DW-1:0] prdata,
   output logic                         pready
);
   import r2fft_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int LW = $clog2(AW + 1);
   localparam int TW = TWIDDLE_BITS;
   localparam int MW = 2 * DATA_W;

   cfg_type cfg;

   r2fft_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   state_type state_ff, state_in;

   logic [LW-1:0]      lg_ff, lg_in, stage_ff, stage_in, lg_req;
   logic               inv_ff, inv_in;
   logic [AW:0]        k_ff, k_in, e_ff, e_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;

   // sample memory: {re, im}
   logic [MW-1:0]      mem [MAX_POINTS];
   logic [MW-1:0]      rda_ff, rdb_ff;
   logic               rd_en, mem_we;
   logic [AW-1:0]      ra, rb, wa;
   logic [MW-1:0]      wd;

   logic               req_acc, rom_en, mul_en, rnd_en;
   logic [AW-1:0]      req_idx, rev, rev_full, tw_idx, o_addr;
   logic [AW:0]        n_pts, m_span, half, e_next;
   logic               swap, k_last, bf_last;
   logic signed [TW-1:0]     w_re, w_im;
   logic signed [DATA_W+1:0] t_re, t_im;
   logic signed [DATA_W-1:0] ea_re, ea_im;
   logic signed [DATA_W:0]   dv_re, dv_im;

   assign req_acc   = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req_idx   = AW'(req.elem_index);
   assign lg_req    = (cfg.log2_size > AW) ? LW'(AW) : LW'(cfg.log2_size);

   for (genvar i = 0; i < AW; i++) begin : g_rev
      assign rev_full[i] = k_ff[AW-1-i];
   end

   assign rev     = rev_full >> (AW - int'(lg_ff));
   assign swap    = {1'b0, rev} > k_ff;
   assign n_pts   = (AW+1)'(1) << lg_ff;
   assign k_last  = (k_ff + 1'b1) == n_pts;
   assign m_span  = (AW+1)'(1) << stage_ff;
   assign half    = m_span >> 1;
   assign e_next  = e_ff + m_span;
   assign o_addr  = AW'(e_ff + half);
   assign tw_idx  = AW'(k_ff << (AW - int'(stage_ff)));
   assign bf_last = (e_next >= n_pts) && ((k_ff + 1'b1) == half) && (stage_ff == lg_ff);

   assign ea_re = $signed(rda_ff[MW-1:DATA_W]);
   assign ea_im = $signed(rda_ff[DATA_W-1:0]);
   // inverse scaling: round half up, arithmetic shift
   assign dv_re = ((DATA_W+1)'(ea_re) + ((DATA_W+1)'(1) << (lg_ff - 1'b1))) >>> lg_ff;
   assign dv_im = ((DATA_W+1)'(ea_im) + ((DATA_W+1)'(1) << (lg_ff - 1'b1))) >>> lg_ff;

   r2fft_twiddle #(
      .MAX_POINTS   (MAX_POINTS),
      .TWIDDLE_BITS (TWIDDLE_BITS)
   ) u_twiddle (
      .clock   (clock),
      .rd_en   (rom_en),
      .tw_idx  (tw_idx),
      .inverse (inv_ff),
      .w_re    (w_re),
      .w_im    (w_im)
   );

   r2fft_butterfly #(
      .TWIDDLE_BITS (TWIDDLE_BITS)
   ) u_butterfly (
      .clock  (clock),
      .mul_en (mul_en),
      .rnd_en (rnd_en),
      .o_re   ($signed(rdb_ff[MW-1:DATA_W])),
      .o_im   ($signed(rdb_ff[DATA_W-1:0])),
      .w_re   (w_re),
      .w_im   (w_im),
      .t_re   (t_re),
      .t_im   (t_im)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req.mode == MODE_READ) begin
                  state_in = ST_RD_WAIT;
               end else if (req.mode == MODE_START) begin
                  state_in = (lg_req == '0) ? ST_DONE : ST_BR_RD;
               end
            end
         end
         ST_RD_WAIT: state_in = ST_IDLE;
         ST_BR_RD: begin
            if (swap) begin
               state_in = ST_BR_W1;
            end else if (k_last) begin
               state_in = ST_BF_RD;
            end
         end
         ST_BR_W1:  state_in = ST_BR_W2;
         ST_BR_W2:  state_in = k_last ? ST_BF_RD : ST_BR_RD;
         ST_BF_RD:  state_in = ST_BF_MUL;
         ST_BF_MUL: state_in = ST_BF_RND;
         ST_BF_RND: state_in = ST_BF_WE;
         ST_BF_WE:  state_in = ST_BF_WO;
         ST_BF_WO: begin
            if (bf_last) begin
               state_in = inv_ff ? ST_DV_RD : ST_DONE;
            end else begin
               state_in = ST_BF_RD;
            end
         end
         ST_DV_RD:  state_in = ST_DV_WR;
         ST_DV_WR:  state_in = k_last ? ST_DONE : ST_DV_RD;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      rd_en    = 1'b0;
      ra       = k_ff[AW-1:0];
      rb       = rev;
      mem_we   = 1'b0;
      wa       = k_ff[AW-1:0];
      wd       = rda_ff;
      rom_en   = 1'b0;
      mul_en   = 1'b0;
      rnd_en   = 1'b0;
      lg_in    = lg_ff;
      inv_in   = inv_ff;
      k_in     = k_ff;
      e_in     = e_ff;
      stage_in = stage_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_kind_in  = rsp_kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               lg_in  = lg_req;
               inv_in = cfg.inverse_mode;
               k_in   = '0;
               if (req.mode == MODE_READ) begin
                  rd_en = 1'b1;
                  ra    = req_idx;
               end else if (req.mode != MODE_START) begin
                  mem_we       = (req.mode == MODE_LOAD);
                  wa           = req_idx;
                  wd           = {DATA_W'(req.in_re), DATA_W'(req.in_im)};
                  rsp_valid_in = 1'b1;
                  rsp_re_in    = '0;
                  rsp_im_in    = '0;
                  rsp_kind_in  = req.mode;
               end
            end
         end
         ST_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_re_in    = ea_re;
            rsp_im_in    = ea_im;
            rsp_kind_in  = MODE_READ;
         end
         ST_BR_RD: begin
            rd_en = swap;
            if (!swap) begin
               k_in = k_ff + 1'b1;
            end
            if (!swap && k_last) begin
               stage_in = LW'(1);
               k_in     = '0;
               e_in     = '0;
            end
         end
         ST_BR_W1: begin
            mem_we = 1'b1;
            wd     = rdb_ff;
         end
         ST_BR_W2: begin
            mem_we = 1'b1;
            wa     = rev;
            wd     = rda_ff;
            k_in   = k_ff + 1'b1;
            if (k_last) begin
               stage_in = LW'(1);
               k_in     = '0;
               e_in     = '0;
            end
         end
         ST_BF_RD: begin
            rd_en  = 1'b1;
            ra     = e_ff[AW-1:0];
            rb     = o_addr;
            rom_en = 1'b1;
         end
         ST_BF_MUL: mul_en = 1'b1;
         ST_BF_RND: rnd_en = 1'b1;
         ST_BF_WE: begin
            mem_we = 1'b1;
            wa     = e_ff[AW-1:0];
            wd     = {sat_data((DATA_W+3)'(ea_re) + (DATA_W+3)'(t_re)),
                      sat_data((DATA_W+3)'(ea_im) + (DATA_W+3)'(t_im))};
         end
         ST_BF_WO: begin
            mem_we = 1'b1;
            wa     = o_addr;
            wd     = {sat_data((DATA_W+3)'(ea_re) - (DATA_W+3)'(t_re)),
                      sat_data((DATA_W+3)'(ea_im) - (DATA_W+3)'(t_im))};
            if (e_next < n_pts) begin
               e_in = e_next;
            end else if ((k_ff + 1'b1) == half) begin
               stage_in = stage_ff + 1'b1;
               k_in     = '0;
               e_in     = '0;
            end else begin
               k_in = k_ff + 1'b1;
               e_in = k_ff + 1'b1;
            end
         end
         ST_DV_RD: rd_en = 1'b1;
         ST_DV_WR: begin
            mem_we = 1'b1;
            wd     = {DATA_W'(dv_re), DATA_W'(dv_im)};
            k_in   = k_ff + 1'b1;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_re_in    = '0;
            rsp_im_in    = '0;
            rsp_kind_in  = MODE_START;
         end
         default: rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         rda_ff <= mem[ra];
         rdb_ff <= mem[rb];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lg_ff        <= '0;
         inv_ff       <= 1'b0;
         k_ff         <= '0;
         e_ff         <= '0;
         stage_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lg_ff        <= lg_in;
         inv_ff       <= inv_in;
         k_ff         <= k_in;
         e_ff         <= e_in;
         stage_ff     <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_re_ff   <= rsp_re_in;
      rsp_im_ff   <= rsp_im_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_re   = rsp_re_ff;
   assign rsp.out_im   = rsp_im_ff;
   assign rsp.ack_kind = rsp_kind_ff;

   `R2_ASSERT_NXT(a_start_busy, clock, reset, req_acc && req.mode == MODE_START, state_ff != ST_IDLE, "start request did not leave idle")
   `R2_ASSERT_IMP(a_idle_write, clock, reset, mem_we && state_ff == ST_IDLE, req_acc && req.mode == MODE_LOAD, "memory write in idle without a load")
   `R2_ASSERT_IMP(a_pass_range, clock, reset, state_ff == ST_BF_RD, stage_ff != '0 && stage_ff <= lg_ff, "butterfly pass out of range")

endmodule
